### rtl/core/asls_pkg.sv
// Shared constants and types for the analog sensor linear scaler.
`timescale 1ns / 1ps

package asls_pkg;

    localparam int ADC_BITS_DEF = 10;
    localparam int SAMPLE_W     = 10;
    localparam int RAW_W        = 19;
    localparam int SCALED_W     = 18;
    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;

    localparam int OHM_K        = 300;
    localparam int MV_K         = 5000;

    localparam logic [1:0] MODE_VOLTAGE    = 2'd0;
    localparam logic [1:0] MODE_RESISTANCE = 2'd1;
    localparam logic [1:0] MODE_LAST_LIN   = 2'd1;
    localparam logic [1:0] MODE_CURVE      = 2'd2;
    localparam logic [1:0] MODE_RESERVED   = 2'd3;

    typedef enum logic [2:0] {
        REG_INPUT_MODE        = 3'd0,
        REG_RAW_POINT_LOW     = 3'd1,
        REG_RAW_POINT_HIGH    = 3'd2,
        REG_SCALED_POINT_LOW  = 3'd3,
        REG_SCALED_POINT_HIGH = 3'd4,
        REG_CLAMP_MINIMUM     = 3'd5,
        REG_CLAMP_MAXIMUM     = 3'd6,
        REG_OUTPUT_MULTIPLIER = 3'd7
    } reg_index_t;

    localparam logic [1:0]         RST_INPUT_MODE        = 2'd0;
    localparam logic [15:0]        RST_RAW_POINT_LOW     = 16'd0;
    localparam logic [15:0]        RST_RAW_POINT_HIGH    = 16'd5000;
    localparam logic signed [15:0] RST_SCALED_POINT_LOW  = 16'sd0;
    localparam logic signed [15:0] RST_SCALED_POINT_HIGH = 16'sd100;
    localparam logic signed [10:0] RST_CLAMP_MINIMUM     = 11'sd0;
    localparam logic signed [10:0] RST_CLAMP_MAXIMUM     = 11'sd100;
    localparam logic [6:0]         RST_OUTPUT_MULTIPLIER = 7'd100;

endpackage

### rtl/core/asls_if.sv
// Valid/ready channel interfaces for samples and results.
`timescale 1ns / 1ps

interface asls_in_if;
    logic                          valid;
    logic                          ready;
    logic [asls_pkg::SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface asls_out_if;
    logic                                valid;
    logic                                ready;
    logic [asls_pkg::RAW_W-1:0]          raw_measure;
    logic signed [asls_pkg::SCALED_W-1:0] scaled_value;
    logic                                calibration_error;

    modport source (output valid, output raw_measure, output scaled_value,
                    output calibration_error, input ready);
    modport sink   (input valid, input raw_measure, input scaled_value,
                    input calibration_error, output ready);
endinterface

### rtl/core/analog_sensor_linear_scaler.sv
// Top level: APB registers, sample conversion, two-point line, clamp and scale.
//
//  channel   dir  handshake       payload
//  samples   in   valid/ready     adc_sample
//  results   out  valid/ready     raw_measure, scaled_value, calibration_error
//  apb       in   psel/penable    paddr, pwdata -> prdata, pready always high
//
// One sample per cycle sustained while the skid stage is empty. Each sample passes the
// conversion stage (loaded at the transfer edge), ADC_BITS+13 divider stages for
// the raw measure, five line/clamp/scale stages, 37 divider stages for the final
// quotient, one sign stage and the output register.
// Reset clears all valid bits and loads the register defaults.
// A result waiting at the output lets one more item advance into the skid
// stage; only then does the pipeline hold and samples.ready drop.
`timescale 1ns / 1ps

module analog_sensor_linear_scaler #(
    parameter int ADC_BITS = asls_pkg::ADC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    asls_in_if.sink                       samples,
    asls_out_if.source                    results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [asls_pkg::ADDR_W-1:0]   paddr,
    input  logic [asls_pkg::DATA_W-1:0]   pwdata,
    output logic [asls_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int MW   = ADC_BITS + 13;
    localparam int VW1  = ADC_BITS + 1;
    localparam int DFW  = MW + 2;
    localparam int P1W  = DFW + 17;
    localparam int NW   = P1W + 1;
    localparam int HW   = 29;
    localparam int PW   = HW + 8;
    localparam int RW   = asls_pkg::RAW_W;
    localparam int SCW  = asls_pkg::SCALED_W;
    localparam int T2W  = MW + 2;
    localparam logic [VW1-1:0] FULL = VW1'(1) << ADC_BITS;

    // configuration registers
    logic [1:0]         input_mode_reg;
    logic [15:0]        raw_point_low_reg;
    logic [15:0]        raw_point_high_reg;
    logic signed [15:0] scaled_point_low_reg;
    logic signed [15:0] scaled_point_high_reg;
    logic signed [10:0] clamp_minimum_reg;
    logic signed [10:0] clamp_maximum_reg;
    logic [6:0]         output_multiplier_reg;

    asls_pkg::reg_index_t cfg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = asls_pkg::reg_index_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_mode_reg        <= asls_pkg::RST_INPUT_MODE;
            raw_point_low_reg     <= asls_pkg::RST_RAW_POINT_LOW;
            raw_point_high_reg    <= asls_pkg::RST_RAW_POINT_HIGH;
            scaled_point_low_reg  <= asls_pkg::RST_SCALED_POINT_LOW;
            scaled_point_high_reg <= asls_pkg::RST_SCALED_POINT_HIGH;
            clamp_minimum_reg     <= asls_pkg::RST_CLAMP_MINIMUM;
            clamp_maximum_reg     <= asls_pkg::RST_CLAMP_MAXIMUM;
            output_multiplier_reg <= asls_pkg::RST_OUTPUT_MULTIPLIER;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                asls_pkg::REG_INPUT_MODE:        input_mode_reg        <= pwdata[1:0];
                asls_pkg::REG_RAW_POINT_LOW:     raw_point_low_reg     <= pwdata[15:0];
                asls_pkg::REG_RAW_POINT_HIGH:    raw_point_high_reg    <= pwdata[15:0];
                asls_pkg::REG_SCALED_POINT_LOW:  scaled_point_low_reg  <= $signed(pwdata[15:0]);
                asls_pkg::REG_SCALED_POINT_HIGH: scaled_point_high_reg <= $signed(pwdata[15:0]);
                asls_pkg::REG_CLAMP_MINIMUM:     clamp_minimum_reg     <= $signed(pwdata[10:0]);
                asls_pkg::REG_CLAMP_MAXIMUM:     clamp_maximum_reg     <= $signed(pwdata[10:0]);
                asls_pkg::REG_OUTPUT_MULTIPLIER: output_multiplier_reg <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            asls_pkg::REG_INPUT_MODE:        prdata = 32'(input_mode_reg);
            asls_pkg::REG_RAW_POINT_LOW:     prdata = 32'(raw_point_low_reg);
            asls_pkg::REG_RAW_POINT_HIGH:    prdata = 32'(raw_point_high_reg);
            asls_pkg::REG_SCALED_POINT_LOW:  prdata = 32'(scaled_point_low_reg);
            asls_pkg::REG_SCALED_POINT_HIGH: prdata = 32'(scaled_point_high_reg);
            asls_pkg::REG_CLAMP_MINIMUM:     prdata = 32'(clamp_minimum_reg);
            asls_pkg::REG_CLAMP_MAXIMUM:     prdata = 32'(clamp_maximum_reg);
            asls_pkg::REG_OUTPUT_MULTIPLIER: prdata = 32'(output_multiplier_reg);
            default:                         prdata = '0;
        endcase
    end

    logic cal_err;
    logic lin_mode;
    logic ohm_mode;
    assign cal_err  = (raw_point_low_reg == raw_point_high_reg);
    assign lin_mode = (input_mode_reg <= asls_pkg::MODE_LAST_LIN);
    assign ohm_mode = (input_mode_reg == asls_pkg::MODE_RESISTANCE);

    // pipeline enable: holds only while the skid stage is occupied
    logic en;
    logic skid_v_reg;
    assign en            = !skid_v_reg;
    assign samples.ready = en;

    // stage 0: conversion operands
    logic [ADC_BITS-1:0] s;
    logic                s0_v_reg;
    logic [MW-1:0]       s0_dvd_reg;
    logic [VW1-1:0]      s0_dvs_reg;

    assign s = ADC_BITS'(samples.adc_sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_dvd_reg <= ohm_mode ? MW'(s) * MW'(asls_pkg::OHM_K)
                                   : MW'(s) * MW'(asls_pkg::MV_K);
            s0_dvs_reg <= ohm_mode ? FULL - VW1'(s) : FULL - VW1'(1);
        end
    end

    logic          d1_v;
    logic [MW-1:0] d1_meas;
    logic          d1_err;

    asls_div #(.DW(MW), .VW(VW1), .TW(1)) u_div_meas (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_v_reg),
        .dividend  (s0_dvd_reg),
        .divisor   (s0_dvs_reg),
        .in_tag    (cal_err),
        .out_valid (d1_v),
        .quotient  (d1_meas),
        .out_tag   (d1_err)
    );

    // stage A: line products
    logic signed [DFW-1:0] diff_x;
    logic signed [16:0]    dscale;
    logic signed [16:0]    dden;
    assign diff_x = $signed(DFW'(d1_meas)) - $signed(DFW'(raw_point_low_reg));
    assign dscale = 17'(scaled_point_high_reg) - 17'(scaled_point_low_reg);
    assign dden   = $signed(17'(raw_point_high_reg)) - $signed(17'(raw_point_low_reg));

    logic                  a_v_reg;
    logic [MW-1:0]         a_meas_reg;
    logic                  a_err_reg;
    logic signed [P1W-1:0] a_p1_reg;
    logic signed [32:0]    a_p2_reg;
    logic signed [HW-1:0]  a_hd_reg;
    logic signed [HW-1:0]  a_ld_reg;
    logic signed [16:0]    a_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= d1_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_meas_reg <= d1_meas;
            a_err_reg  <= d1_err;
            a_p1_reg   <= P1W'(diff_x) * P1W'(dscale);
            a_p2_reg   <= 33'(scaled_point_low_reg) * 33'(dden);
            a_hd_reg   <= HW'(clamp_maximum_reg) * HW'(dden);
            a_ld_reg   <= HW'(clamp_minimum_reg) * HW'(dden);
            a_den_reg  <= dden;
        end
    end

    // stage B: numerator, positive denominator
    logic signed [NW-1:0] sum_b;
    logic signed [NW-1:0] num_b_next;
    logic [15:0]          den_b_next;
    logic signed [HW-1:0] hd_b_next;
    logic signed [HW-1:0] ld_b_next;

    assign sum_b = NW'(a_p1_reg) + NW'(a_p2_reg);

    always_comb
    begin
        if (!lin_mode)
        begin
            num_b_next = '0;
            den_b_next = 16'd1;
            hd_b_next  = HW'(clamp_maximum_reg);
            ld_b_next  = HW'(clamp_minimum_reg);
        end
        else if (a_err_reg)
        begin
            num_b_next = NW'(scaled_point_low_reg);
            den_b_next = 16'd1;
            hd_b_next  = HW'(clamp_maximum_reg);
            ld_b_next  = HW'(clamp_minimum_reg);
        end
        else if (a_den_reg < 0)
        begin
            num_b_next = -sum_b;
            den_b_next = 16'(-a_den_reg);
            hd_b_next  = -a_hd_reg;
            ld_b_next  = -a_ld_reg;
        end
        else
        begin
            num_b_next = sum_b;
            den_b_next = a_den_reg[15:0];
            hd_b_next  = a_hd_reg;
            ld_b_next  = a_ld_reg;
        end
    end

    logic                 b_v_reg;
    logic [MW-1:0]        b_meas_reg;
    logic                 b_err_reg;
    logic signed [NW-1:0] b_num_reg;
    logic [15:0]          b_den_reg;
    logic signed [HW-1:0] b_hd_reg;
    logic signed [HW-1:0] b_ld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_meas_reg <= a_meas_reg;
            b_err_reg  <= a_err_reg;
            b_num_reg  <= num_b_next;
            b_den_reg  <= den_b_next;
            b_hd_reg   <= hd_b_next;
            b_ld_reg   <= ld_b_next;
        end
    end

    // stage C: clamp, maximum first then minimum
    logic                 over_c;
    logic                 under_c;
    logic signed [HW-1:0] num_c_next;
    logic [15:0]          den_c_next;

    assign over_c  = (b_num_reg > NW'(b_hd_reg));
    assign under_c = over_c ? (clamp_maximum_reg < clamp_minimum_reg)
                            : (b_num_reg < NW'(b_ld_reg));

    always_comb
    begin
        if (under_c)
        begin
            num_c_next = HW'(clamp_minimum_reg);
            den_c_next = 16'd1;
        end
        else if (over_c)
        begin
            num_c_next = HW'(clamp_maximum_reg);
            den_c_next = 16'd1;
        end
        else
        begin
            num_c_next = HW'(b_num_reg);
            den_c_next = b_den_reg;
        end
    end

    logic                 c_v_reg;
    logic [MW-1:0]        c_meas_reg;
    logic                 c_err_reg;
    logic signed [HW-1:0] c_num_reg;
    logic [15:0]          c_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
        end
        else if (en)
        begin
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_meas_reg <= b_meas_reg;
            c_err_reg  <= b_err_reg;
            c_num_reg  <= num_c_next;
            c_den_reg  <= den_c_next;
        end
    end

    // stage D: multiplier
    logic                 d_v_reg;
    logic [MW-1:0]        d_meas_reg;
    logic                 d_err_reg;
    logic signed [PW-1:0] d_prod_reg;
    logic [15:0]          d_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
        end
        else if (en)
        begin
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_meas_reg <= c_meas_reg;
            d_err_reg  <= c_err_reg;
            d_prod_reg <= PW'(c_num_reg) * PW'($signed({1'b0, output_multiplier_reg}));
            d_den_reg  <= c_den_reg;
        end
    end

    // stage E: magnitude for truncation toward zero
    logic          e_v_reg;
    logic [PW-1:0] e_mag_reg;
    logic [15:0]   e_den_reg;
    logic [T2W-1:0] e_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_mag_reg <= (d_prod_reg < 0) ? PW'(-d_prod_reg) : PW'(d_prod_reg);
            e_den_reg <= d_den_reg;
            e_tag_reg <= {(d_prod_reg < 0), d_err_reg, d_meas_reg};
        end
    end

    logic           d2_v;
    logic [PW-1:0]  d2_q;
    logic [T2W-1:0] d2_tag;

    asls_div #(.DW(PW), .VW(16), .TW(T2W)) u_div_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_v_reg),
        .dividend  (e_mag_reg),
        .divisor   (e_den_reg),
        .in_tag    (e_tag_reg),
        .out_valid (d2_v),
        .quotient  (d2_q),
        .out_tag   (d2_tag)
    );

    // stage F: restore sign
    logic                  f_v_reg;
    logic [RW-1:0]         f_raw_reg;
    logic signed [SCW-1:0] f_scaled_reg;
    logic                  f_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f_v_reg <= d2_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_raw_reg    <= d2_tag[RW-1:0];
            f_err_reg    <= d2_tag[MW];
            f_scaled_reg <= d2_tag[MW+1] ? SCW'(-d2_q) : SCW'(d2_q);
        end
    end

    // output register and skid stage
    logic                  out_v_reg;
    logic [RW-1:0]         out_raw_reg;
    logic signed [SCW-1:0] out_scaled_reg;
    logic                  out_err_reg;
    logic [RW-1:0]         skid_raw_reg;
    logic signed [SCW-1:0] skid_scaled_reg;
    logic                  skid_err_reg;
    logic                  push;
    logic                  pop;

    assign push = en && f_v_reg;
    assign pop  = out_v_reg && results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || pop)
        begin
            out_v_reg  <= skid_v_reg || push;
            skid_v_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || pop)
        begin
            if (skid_v_reg)
            begin
                out_raw_reg    <= skid_raw_reg;
                out_scaled_reg <= skid_scaled_reg;
                out_err_reg    <= skid_err_reg;
            end
            else
            begin
                out_raw_reg    <= f_raw_reg;
                out_scaled_reg <= f_scaled_reg;
                out_err_reg    <= f_err_reg;
            end
        end
        else if (push)
        begin
            skid_raw_reg    <= f_raw_reg;
            skid_scaled_reg <= f_scaled_reg;
            skid_err_reg    <= f_err_reg;
        end
    end

    assign results.valid             = out_v_reg;
    assign results.raw_measure       = out_raw_reg;
    assign results.scaled_value      = out_scaled_reg;
    assign results.calibration_error = out_err_reg;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid stage full while output register empty");

    a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (out_err_reg == cal_err))
        else $error("calibration error flag disagrees with registers");

    a_hold_on_skid: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg && !pop |=> skid_v_reg && $stable(skid_raw_reg))
        else $error("skid entry lost during output stall");
`endif

endmodule

### rtl/core/asls_div.sv
// Pipelined restoring divider, one quotient bit per stage, tag carried along.
`timescale 1ns / 1ps

module asls_div #(
    parameter int DW = 23,
    parameter int VW = 11,
    parameter int TW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [DW-1:0] quotient,
    output logic [TW-1:0] out_tag
);

    logic          v_reg   [DW];
    logic [VW-1:0] rem_reg [DW];
    logic [DW-1:0] q_reg   [DW];
    logic [VW-1:0] d_reg   [DW];
    logic [TW-1:0] tag_reg [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic          v_in;
        logic [VW-1:0] r_in;
        logic [DW-1:0] q_in;
        logic [VW-1:0] d_in;
        logic [TW-1:0] t_in;
        logic [VW:0]   trial;
        logic [VW:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in = in_valid;
            assign r_in = '0;
            assign q_in = dividend;
            assign d_in = divisor;
            assign t_in = in_tag;
        end
        else begin : g_next
            assign v_in = v_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign q_in = q_reg[k-1];
            assign d_in = d_reg[k-1];
            assign t_in = tag_reg[k-1];
        end

        assign trial = {r_in, q_in[DW-1]};
        assign diff  = trial - {1'b0, d_in};
        assign ge    = (trial >= {1'b0, d_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[VW-1:0] : trial[VW-1:0];
                q_reg[k]   <= {q_in[DW-2:0], ge};
                d_reg[k]   <= d_in;
                tag_reg[k] <= t_in;
            end
        end
    end

    assign out_valid = v_reg[DW-1];
    assign quotient  = q_reg[DW-1];
    assign out_tag   = tag_reg[DW-1];

endmodule
